>>> rtl/fmf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmf_pkg
// Shared codes and constants for the FIX message framer.
// ---------------------------------------------------------------------------
package fmf_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_BAD_CSUM   = 3'd4;
  localparam logic [2:0] ST_MALFORMED  = 3'd5;
  localparam logic [2:0] ST_TOO_LONG   = 3'd6;

  localparam int unsigned MinBuffer  = 20;
  localparam int unsigned TrailerLen = 7;
  localparam int unsigned DataW      = 88;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic [DataW-1:0]  data;
  } result_t;

  function automatic logic [7:0] hdr_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h38;
      4'd1:    c = 8'h3D;
      4'd2:    c = 8'h46;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h58;
      4'd5:    c = 8'h2E;
      4'd6:    c = 8'h34;
      4'd7:    c = 8'h2E;
      4'd8:    c = 8'h34;
      4'd10:   c = 8'h39;
      default: c = 8'h3D;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/fmf_out_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmf_out_fifo
// Four-entry result queue, takes up to two results per cycle.
// ---------------------------------------------------------------------------
module fmf_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr0_i,
  input  logic            wr1_i,
  input  fmf_pkg::result_t din0_i,
  input  fmf_pkg::result_t din1_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output fmf_pkg::result_t dout_o
);
  import fmf_pkg::*;

  result_t     mem_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;
  logic        pop;
  logic [1:0]  nwr;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign dout_o  = mem_q[rd_q];
  assign nwr     = {1'b0, wr0_i} + {1'b0, wr1_i};

  always_ff @(posedge clk_i) begin
    if (wr0_i) begin
      mem_q[wr_q] <= din0_i;
    end
    if (wr1_i) begin
      mem_q[wr_q + {1'b0, wr0_i}] <= din1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + nwr;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, nwr} - {2'b0, pop};
    end
  end

endmodule

>>> rtl/fix_message_framer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fix_message_framer_unit
// Byte-serial FIX 4.4 framer: header, body length, checksum, field reports.
// ---------------------------------------------------------------------------
// channel  | dir | tdata                    | tuser       | tlast
// s_axis   | in  | data_byte                | -           | buffer_end
// m_axis   | out | tag,off,len,st,cons,csum | result_kind | last
// apb      | in  | soh_char at 0x0          | -           | -
// One byte per cycle; the parse state updates in the accepting cycle.
// Results go through a four-entry queue; input stalls when it holds three+.
// Up to two results per byte; sustained rate is one byte per cycle while
// the output drains. Reset clears the parser, queue and delimiter (1).
// ---------------------------------------------------------------------------
module fix_message_framer_unit #(
  parameter int unsigned MAX_MESSAGE_BYTES = 131072,
  parameter int unsigned MAX_BODY_LENGTH   = 65535,
  parameter int unsigned MAX_TAG           = 1048575
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [19:0] field_tag, [36:20] value_offset, [53:37] value_length,
  // [56:54] status, [73:57] consumed, [81:74] checksum_value, rest zero
  output logic [fmf_pkg::DataW-1:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fmf_pkg::*;

  localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int LW = $clog2(MAX_BODY_LENGTH + 2);
  localparam int TW = $clog2(MAX_TAG + 2);
  localparam int SW = ((CW > LW) ? CW : LW) + 2;

  typedef enum logic [2:0] {
    PH_HDR, PH_LEN, PH_BODY, PH_TRL, PH_WAIT, PH_DROP
  } phase_e;

  typedef struct packed {
    phase_e        phase;
    logic [CW-1:0] cnt;
    logic [7:0]    sum;
    logic [LW-1:0] blen;
    logic [CW-1:0] bend;
    logic [TW-1:0] tag;
    logic [CW-1:0] fstart;
    logic [2:0]    perr;
    logic [9:0]    trl;
    logic [2:0]    derr;
    logic          tag_seen;
    logic          in_val;
    logic          len_seen;
    logic          len_bad;
    logic          trl_bad;
  } pstate_t;

  localparam pstate_t ClearState = '{phase: PH_HDR, default: '0};

  pstate_t    s_q, s_d;
  logic [7:0] soh_q;
  logic       acc, room;
  logic       r0_v, r1_v;
  result_t    r0, r1, rout;

  assign acc           = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;
  assign pready        = 1'b1;
  assign prdata        = (paddr == 3'd0) ? {24'd0, soh_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soh_q <= 8'd1;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      soh_q <= pwdata[7:0];
    end
  end

  function automatic result_t mk_res(input logic kind, input logic [TW-1:0] tag,
                                     input logic [CW-1:0] off, input logic [CW-1:0] len,
                                     input logic [2:0] st, input logic [CW-1:0] cons,
                                     input logic [7:0] cs);
    result_t r;
    logic [19:0] t20;
    logic [16:0] o17, l17, c17;
    t20 = 20'(tag);
    o17 = 17'(off);
    l17 = 17'(len);
    c17 = 17'(cons);
    r.kind = kind;
    r.last = 1'b0;
    r.data = {6'd0, cs, c17, st, l17, o17, t20};
    return r;
  endfunction

  always_comb begin
    logic [7:0]      b;
    logic            fin;
    logic [CW-1:0]   pos, k;
    logic            st_v, cand, isdig;
    logic [2:0]      st;
    logic [TW-1:0]   ftag;
    logic [CW-1:0]   foff, flen;
    logic [TW+3:0]   tv;
    logic [LW+3:0]   lv;
    logic [SW-1:0]   lim;
    logic [7:0]      want;
    result_t         fres, sres;

    b     = s_axis_tdata;
    fin   = s_axis_tlast;
    s_d   = s_q;
    pos   = s_q.cnt;
    k     = '0;
    st_v  = 1'b0;
    st    = ST_OK;
    cand  = 1'b0;
    ftag  = '0;
    foff  = '0;
    flen  = '0;
    tv    = '0;
    lv    = '0;
    lim   = '0;
    want  = '0;
    fres  = '0;
    sres  = '0;
    isdig = (b >= 8'h30) && (b <= 8'h39);
    r0_v  = 1'b0;
    r1_v  = 1'b0;
    r0    = '0;
    r1    = '0;

    if (s_q.phase == PH_DROP) begin
      if (fin) begin
        s_d = ClearState;
      end
    end else if (s_q.phase == PH_WAIT) begin
      if (s_q.cnt < CW'(MinBuffer)) begin
        s_d.cnt = s_q.cnt + 1'b1;
      end
      if (s_d.cnt >= CW'(MinBuffer)) begin
        r0_v = 1'b1;
        r0 = mk_res(1'b1, '0, '0, '0, s_q.derr, '0, 8'd0);
        s_d.phase = PH_DROP;
      end else if (fin) begin
        r0_v = 1'b1;
        r0 = mk_res(1'b1, '0, '0, '0, ST_INCOMPLETE, '0, 8'd0);
      end
      r0.last = 1'b1;
      if (fin) begin
        s_d = ClearState;
      end
    end else begin
      s_d.cnt = s_q.cnt + 1'b1;
      if (s_q.phase != PH_TRL) begin
        s_d.sum = s_q.sum + b;
        if (s_q.perr == 3'd0) begin
          if (!s_q.in_val) begin
            if (b == 8'h3D) begin
              if (!s_q.tag_seen) s_d.perr = ST_MALFORMED;
              else if (s_q.tag > TW'(MAX_TAG)) s_d.perr = ST_TOO_LONG;
              else begin
                s_d.in_val = 1'b1;
                s_d.fstart = pos + 1'b1;
              end
            end else if (isdig) begin
              tv = ({4'd0, s_q.tag} << 3) + ({4'd0, s_q.tag} << 1) + (TW+4)'(b - 8'h30);
              s_d.tag = (tv > (TW+4)'(MAX_TAG)) ? TW'(MAX_TAG + 1) : tv[TW-1:0];
              s_d.tag_seen = 1'b1;
            end else begin
              s_d.perr = ST_MALFORMED;
            end
          end else if (b == soh_q) begin
            cand = 1'b1;
            ftag = s_q.tag;
            foff = s_q.fstart;
            flen = pos - s_q.fstart;
            s_d.in_val = 1'b0;
            s_d.tag_seen = 1'b0;
            s_d.tag = '0;
          end
        end
      end
      unique case (s_q.phase)
        PH_HDR: begin
          want = (pos < CW'(9)) ? hdr_char(pos[3:0]) :
                 (pos == CW'(9)) ? soh_q : hdr_char(pos[3:0]);
          if (b != want) begin
            st_v = 1'b1; st = ST_BAD_HEADER;
          end else if (pos == CW'(11)) begin
            s_d.phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b == soh_q) begin
            lim = SW'(pos) + SW'(s_q.blen) + SW'(1 + TrailerLen);
            if (!s_q.len_seen || s_q.len_bad) begin
              st_v = 1'b1; st = ST_BAD_LENGTH;
            end else if (s_q.blen > LW'(MAX_BODY_LENGTH) ||
                         lim >= SW'(MAX_MESSAGE_BYTES)) begin
              st_v = 1'b1; st = ST_TOO_LONG;
            end else begin
              s_d.bend  = CW'(SW'(pos) + SW'(s_q.blen) + SW'(1));
              s_d.phase = (s_q.blen == '0) ? PH_TRL : PH_BODY;
            end
          end else begin
            if (isdig) begin
              lv = ({4'd0, s_q.blen} << 3) + ({4'd0, s_q.blen} << 1) + (LW+4)'(b - 8'h30);
              s_d.blen = (lv > (LW+4)'(MAX_BODY_LENGTH)) ? LW'(MAX_BODY_LENGTH + 1)
                                                         : lv[LW-1:0];
              s_d.len_seen = 1'b1;
            end else begin
              s_d.len_bad = 1'b1;
            end
            if (SW'(s_d.cnt) + SW'(TrailerLen + 1) >= SW'(MAX_MESSAGE_BYTES)) begin
              st_v = 1'b1; st = ST_TOO_LONG;
            end
          end
        end
        PH_BODY: begin
          if (s_d.cnt >= s_q.bend) s_d.phase = PH_TRL;
        end
        PH_TRL: begin
          k = pos - s_q.bend;
          if (k == '0) begin
            if (s_q.perr == 3'd0) begin
              if (s_q.in_val && b == soh_q) begin
                cand = 1'b1;
                ftag = s_q.tag;
                foff = s_q.fstart;
                flen = s_q.bend - s_q.fstart;
              end else if (s_q.in_val || s_q.tag_seen) begin
                s_d.perr = ST_MALFORMED;
              end
            end
            if (b != 8'h31) s_d.trl_bad = 1'b1;
          end else if (k == CW'(1)) begin
            if (b != 8'h30) s_d.trl_bad = 1'b1;
          end else if (k == CW'(2)) begin
            if (b != 8'h3D) s_d.trl_bad = 1'b1;
          end else if (k < CW'(6)) begin
            if (isdig) s_d.trl = 10'((s_q.trl << 3) + (s_q.trl << 1) + 10'(b - 8'h30));
            else s_d.trl_bad = 1'b1;
          end else begin
            if (b != soh_q) s_d.trl_bad = 1'b1;
            st_v = 1'b1;
            if (s_d.trl_bad || s_q.trl != {2'b0, s_q.sum}) st = ST_BAD_CSUM;
            else if (s_d.perr != 3'd0) st = s_d.perr;
            else st = ST_OK;
          end
        end
        default: ;
      endcase

      if (st_v && (st != ST_OK || s_q.phase != PH_TRL)) begin
        if (s_d.cnt >= CW'(MinBuffer)) begin
          s_d.phase = PH_DROP;
        end else begin
          s_d.phase = PH_WAIT;
          s_d.derr  = st;
          st_v = 1'b0;
        end
      end

      fres = mk_res(1'b0, ftag, foff, flen, ST_OK, '0, 8'd0);
      if (st_v) begin
        sres = (st == ST_OK) ? mk_res(1'b1, '0, '0, '0, st, s_d.cnt, s_q.trl[7:0])
                             : mk_res(1'b1, '0, '0, '0, st, '0, 8'd0);
      end else begin
        sres = mk_res(1'b1, '0, '0, '0, ST_INCOMPLETE, '0, 8'd0);
      end
      sres.last = 1'b1;
      fres.last = !(st_v || fin);

      if (cand && (!st_v || st == ST_OK) && s_d.phase != PH_WAIT) begin
        r0_v = 1'b1;
        r0 = fres;
        r1_v = st_v || fin;
        r1 = sres;
      end else begin
        r0_v = st_v || fin;
        r0 = sres;
      end
      if ((st_v && st == ST_OK) || fin) begin
        s_d = ClearState;
      end
    end

    r0_v = r0_v && acc;
    r1_v = r1_v && acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= ClearState;
    end else if (acc) begin
      s_q <= s_d;
    end
  end

  fmf_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr0_i   (r0_v),
    .wr1_i   (r1_v),
    .din0_i  (r0),
    .din1_i  (r1),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .dout_o  (rout)
  );

  assign m_axis_tdata = rout.data;
  assign m_axis_tuser = rout.kind;
  assign m_axis_tlast = rout.last;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the FIX message framer: well-formed and broken
// messages with random content, a fixed set of delimiter settings and bus stalls;
// every result is compared against an in-bench model of the parser.
// ---------------------------------------------------------------------------
module tb;
  import fmf_pkg::*;

  localparam int unsigned MaxMsg  = 131072;
  localparam int unsigned MaxBody = 65535;
  localparam int unsigned MaxTag  = 1048575;

  typedef enum logic [2:0] {
    PH_HDR, PH_LEN, PH_BODY, PH_TRL, PH_WAIT, PH_DROP
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [19:0] tag;
    logic [16:0] off;
    logic [16:0] len;
    logic [2:0]  st;
    logic [16:0] cons;
    logic [7:0]  csum;
    logic        last;
  } frame_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fix_message_framer_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser model state
  logic [7:0]  delim;
  phase_e      ph;
  int unsigned bcount, blen, bend, tacc, fstart, tval;
  logic [7:0]  rsum;
  logic [2:0]  pend_err, held_err;
  bit          tag_seen, in_val, len_seen, len_bad, trl_bad;

  frame_res_t  expected_q[$];
  int          errors = 0;
  bit          hold_rx = 1'b0;
  byte         msg[$];

  function automatic void clear_msg();
    ph = PH_HDR; bcount = 0; rsum = 0; blen = 0; bend = 0; tacc = 0;
    fstart = 0; pend_err = 0; tval = 0; held_err = 0;
    tag_seen = 0; in_val = 0; len_seen = 0; len_bad = 0; trl_bad = 0;
  endfunction

  function automatic void push_res(logic kind, int unsigned tg, int unsigned of,
                                   int unsigned ln, logic [2:0] st,
                                   int unsigned cn, int unsigned cs);
    frame_res_t r;
    r = '{kind, tg[19:0], of[16:0], ln[16:0], st, cn[16:0], cs[7:0], 1'b0};
    expected_q.push_back(r);
  endfunction

  function automatic void field_err(logic [2:0] c);
    if (pend_err == 0) pend_err = c;
  endfunction

  function automatic int decide_err(logic [2:0] c);
    if (bcount >= MinBuffer) begin
      ph = PH_DROP;
      return c;
    end
    ph = PH_WAIT;
    held_err = c;
    return 255;
  endfunction

  function automatic bit walk_field(logic [7:0] b, int unsigned pos,
                                    output int unsigned tg, output int unsigned of,
                                    output int unsigned ln);
    int unsigned v;
    tg = 0; of = 0; ln = 0;
    if (pend_err != 0) return 0;
    if (!in_val) begin
      if (b == "=") begin
        if (!tag_seen) field_err(ST_MALFORMED);
        else if (tacc > MaxTag) field_err(ST_TOO_LONG);
        else begin
          in_val = 1; fstart = pos + 1;
        end
      end else if (b >= "0" && b <= "9") begin
        v = tacc * 10 + (b - "0");
        tacc = v > MaxTag ? MaxTag + 1 : v;
        tag_seen = 1;
      end else field_err(ST_MALFORMED);
      return 0;
    end
    if (b != delim) return 0;
    tg = tacc; of = fstart; ln = pos - fstart;
    in_val = 0; tag_seen = 0; tacc = 0;
    return 1;
  endfunction

  function automatic logic [7:0] hdr_byte(int unsigned i);
    string s;
    s = "8=FIX.4.4";
    return s[i];
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fin);
    int n0, st, pos, k, v;
    int unsigned cons, cs, tg, of, ln;
    bit cand;
    logic [7:0] want;
    n0 = expected_q.size(); st = 255; cons = 0; cs = 0; cand = 0;
    tg = 0; of = 0; ln = 0;
    if (ph == PH_DROP) begin
      if (fin) clear_msg();
      return;
    end
    if (ph == PH_WAIT) begin
      if (bcount < MinBuffer) bcount++;
      if (bcount >= MinBuffer) begin
        push_res(1, 0, 0, 0, held_err, 0, 0);
        ph = PH_DROP;
      end else if (fin) push_res(1, 0, 0, 0, ST_INCOMPLETE, 0, 0);
      if (fin) clear_msg();
      if (expected_q.size() > n0) expected_q[$].last = 1;
      return;
    end
    pos = bcount;
    bcount++;
    if (ph != PH_TRL) begin
      rsum = rsum + b;
      cand = walk_field(b, pos, tg, of, ln);
    end
    case (ph)
      PH_HDR: begin
        want = pos < 9 ? hdr_byte(pos) : pos == 9 ? delim : pos == 10 ? "9" : "=";
        if (b != want) st = decide_err(ST_BAD_HEADER);
        else if (pos == 11) ph = PH_LEN;
      end
      PH_LEN: begin
        if (b == delim) begin
          if (!len_seen || len_bad) st = decide_err(ST_BAD_LENGTH);
          else if (blen > MaxBody || pos + 1 + blen + TrailerLen >= MaxMsg)
            st = decide_err(ST_TOO_LONG);
          else begin
            bend = pos + 1 + blen;
            ph = blen == 0 ? PH_TRL : PH_BODY;
          end
        end else begin
          if (b >= "0" && b <= "9") begin
            v = blen * 10 + (b - "0");
            blen = v > MaxBody ? MaxBody + 1 : v;
            len_seen = 1;
          end else len_bad = 1;
          if (bcount + TrailerLen + 1 >= MaxMsg) st = decide_err(ST_TOO_LONG);
        end
      end
      PH_BODY: if (bcount >= bend) ph = PH_TRL;
      default: begin
        k = pos - bend;
        if (k == 0) begin
          if (pend_err == 0) begin
            if (in_val && b == delim) begin
              cand = 1; tg = tacc; of = fstart; ln = bend - fstart;
            end else if (in_val || tag_seen) field_err(ST_MALFORMED);
          end
          if (b != "1") trl_bad = 1;
        end else if (k == 1) begin
          if (b != "0") trl_bad = 1;
        end else if (k == 2) begin
          if (b != "=") trl_bad = 1;
        end else if (k < 6) begin
          if (b >= "0" && b <= "9") tval = tval * 10 + (b - "0");
          else trl_bad = 1;
        end else begin
          if (b != delim) trl_bad = 1;
          if (trl_bad || tval != rsum) st = decide_err(ST_BAD_CSUM);
          else if (pend_err != 0) st = decide_err(pend_err);
          else begin
            st = ST_OK; cons = bcount; cs = tval;
          end
        end
      end
    endcase
    if (cand && (st == 255 || st == 0) && ph != PH_WAIT) push_res(0, tg, of, ln, 0, 0, 0);
    if (st != 255) begin
      push_res(1, 0, 0, 0, st, cons, cs);
      if (st == 0) clear_msg();
    end else if (fin) push_res(1, 0, 0, 0, ST_INCOMPLETE, 0, 0);
    if (fin) clear_msg();
    if (expected_q.size() > n0) expected_q[$].last = 1;
  endfunction

  // receiver
  int rx_wait = 0;
  always @(posedge clk_i) begin
    frame_res_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[19:0], m_axis_tdata[36:20], m_axis_tdata[53:37],
              m_axis_tdata[56:54], m_axis_tdata[73:57], m_axis_tdata[81:74], m_axis_tlast};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r || m_axis_tdata[DataW-1:82] !== '0) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
          errors++;
        end
      end
      rx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    end
    if (hold_rx) m_axis_tready <= 1'b0;
    else if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  bit burst_mode = 0;

  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    gap = burst_mode ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_byte(b, fin);
  endtask

  task automatic idle_in();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_msg(bit end_last);
    foreach (msg[i]) send_byte(msg[i], end_last && i == msg.size() - 1);
  endtask

  task automatic drain();
    idle_in();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [7:0] v);
    psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    delim = v;
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endfunction

  function automatic void add_num(int unsigned v);
    add_str($sformatf("%0d", v));
  endfunction

  // build a message with random fields; corrupt per mode
  function automatic void build_msg(int nf, int mode);
    byte body[$];
    int unsigned sum, blen_i;
    string tmp;
    msg.delete();
    for (int f = 0; f < nf; f++) begin
      tmp = $sformatf("%0d=", $urandom_range(0, 9) == 0 ? $urandom_range(0, MaxTag + 5)
                                                        : $urandom_range(1, 999));
      for (int i = 0; i < tmp.len(); i++) body.push_back(tmp[i]);
      for (int i = $urandom_range(0, 6); i > 0; i--) begin
        byte c;
        c = 8'($urandom_range(32, 126));
        if (c == delim) c = "A";
        body.push_back(c);
      end
      body.push_back(delim);
    end
    if (mode == 5 && body.size() > 0) body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
    add_str("8=FIX.4.4"); msg.push_back(delim); add_str("9=");
    blen_i = body.size();
    if (mode == 3) add_str("1x"); else add_num(mode == 6 ? blen_i + 1 : blen_i);
    msg.push_back(delim);
    foreach (body[i]) msg.push_back(body[i]);
    sum = 0;
    foreach (msg[i]) sum += msg[i];
    if (mode == 6) msg.push_back("1");
    add_str($sformatf("10=%03d", mode == 4 ? (sum + 1) % 256 : sum % 256));
    msg.push_back(delim);
    if (mode == 2) msg[$urandom_range(0, 11)] = 8'($urandom);
    if (mode == 1) msg = msg[0:$urandom_range(0, msg.size() - 2)];
  endfunction

  task automatic test_directed();
    build_msg(2, 0); send_msg(0);
    msg = '{8'h00, 8'hFF}; send_msg(1);
    build_msg(0, 0); send_msg(1);
    build_msg(1, 2); send_msg(1);
    build_msg(1, 3); send_msg(1);
    build_msg(2, 4); send_msg(1);
    drain();
  endtask

  task automatic test_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      int mode;
      mode = $urandom_range(0, 9);
      if (mode > 6) mode = 0;
      build_msg($urandom_range(0, 4), mode);
      sent += msg.size();
      send_msg(mode != 0 || $urandom_range(0, 3) == 0);
    end
    idle_in();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1;
        repeat (200) @(posedge clk_i);
        hold_rx = 0;
      end
      begin
        burst_mode = 1;
        test_random(60);
        burst_mode = 0;
      end
    join
    drain();
  endtask

  task automatic test_delims();
    logic [7:0] vals[4];
    vals = '{8'd0, 8'd255, 8'h7C, 8'd1};
    foreach (vals[i]) begin
      msg = '{8'h00}; send_byte(8'h00, 1);
      drain();
      apb_write(vals[i]);
      test_random(150);
      msg.delete(); send_byte(8'h00, 1);
      drain();
    end
  endtask

  initial begin
    delim = 8'd1;
    clear_msg();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(500);
    send_byte(8'h00, 1);
    drain();
    test_delims();
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> fix_message_framer_unit.f
rtl/fmf_pkg.sv
rtl/fmf_out_fifo.sv
rtl/fix_message_framer_unit.sv
bench/tb.sv
